[hdl/asymmetric_wavefolder_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the asymmetric wavefolder
// Expand to concurrent checks in simulation and to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASYMMETRIC_WAVEFOLDER_ASSERT_SVH
`define ASYMMETRIC_WAVEFOLDER_ASSERT_SVH
`ifndef SYNTHESIS
`define AVF_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: check failed");
`define AVF_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");
`else
`define AVF_ASSERT(name, clk, rstn, prop)
`define AVF_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

[hdl/avf_pkg.sv]
// ---------------------------------------------------------------------------
// avf_pkg
// Types, constants and constant tables of the asymmetric wavefolder.
// ---------------------------------------------------------------------------
package avf_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int FRAC           = SAMPLE_BITS - 1;
    localparam int TANH_N         = 256;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 13;
    localparam int PG_BITS        = 21;

    // floor(u / 5) as (u * DIV5_RECIP) >> 32, exact for u < 2^28
    localparam logic [29:0] DIV5_RECIP = 30'd858993460;
    // 5 * 2^25, lifts the driven product above zero before the divide
    localparam logic signed [28:0] DIV5_OFFSET = 29'sd167772160;
    localparam logic [16:0] AG_FLOOR  = 17'd6554;
    localparam logic [16:0] MIX_SCALE = 17'd62259;

    // 16/N in Q32, argument of the exp series
    localparam logic [63:0] TANH_ARG = (64'd16 << 32) / TANH_N;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DRIVE_GAIN   = 3'd0,
        CFG_BIAS_OFFSET  = 3'd1,
        CFG_ASYMMETRY    = 3'd2,
        CFG_WET_MIX      = 3'd3,
        CFG_TRIM_HALF_DB = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        GS_IDLE,
        GS_DIVIDE,
        GS_SCALE
    } t_gain_state;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          last_in_block;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          last_out;
    } t_out_item;

    typedef struct packed {
        logic [12:0]         drive_gain;
        logic signed [9:0]   bias_offset;
        logic [8:0]          asymmetry;
        logic [8:0]          wet_mix;
        logic [PG_BITS-1:0]  pg;
        logic                pg_ok;
    } t_cfg;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x;
        logic signed [16:0]            y;
        logic                          last;
    } t_fold_item;

    typedef logic [19:0] t_trim_base [40];
    typedef logic [19:0] t_trim_gain [73];
    typedef logic [15:0] t_tanh_tab [TANH_N+1];

    localparam t_trim_base TRIM_TAB = '{
        20'd65536,  20'd69419,  20'd73533,  20'd77890,  20'd82505,
        20'd87394,  20'd92572,  20'd98057,  20'd103868, 20'd110022,
        20'd116541, 20'd123447, 20'd130762, 20'd138510, 20'd146717,
        20'd155410, 20'd164619, 20'd174373, 20'd184706, 20'd195650,
        20'd207243, 20'd219523, 20'd232531, 20'd246309, 20'd260904,
        20'd276363, 20'd292739, 20'd310084, 20'd328458, 20'd347920,
        20'd368536, 20'd390373, 20'd413504, 20'd438006, 20'd463959,
        20'd491451, 20'd520571, 20'd551417, 20'd584090, 20'd618700
    };

    // Restoring long division, one quotient bit per pass
    function automatic logic [63:0] long_div(logic [63:0] a, logic [63:0] b);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], a[i]};
            if (r >= {1'b0, b}) begin
                r    = r - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Trim gain for every half-dB step from -48 to +24, entry 0 is -48
    function automatic t_trim_gain build_trim();
        t_trim_gain g;
        int h;
        for (int i = 0; i < 73; i++) begin
            h = i - 48;
            if (h >= 0) begin
                g[i] = TRIM_TAB[h];
            end else if (h >= -40) begin
                g[i] = 20'(long_div(64'(TRIM_TAB[h + 40]) + 64'd5, 64'd10));
            end else begin
                g[i] = 20'(long_div(64'(TRIM_TAB[h + 80]) + 64'd50, 64'd100));
            end
        end
        return g;
    endfunction

    // tanh(8k/N) in Q1.15, from a series for exp(-16/N) and repeated products
    function automatic t_tanh_tab build_tanh();
        t_tanh_tab tab;
        logic [63:0] one32;
        logic [63:0] term;
        logic signed [63:0] sum;
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] den;
        one32 = 64'h1_0000_0000;
        term  = one32;
        sum   = one32;
        for (int n = 1; n <= 17; n++) begin
            term = long_div((term * TANH_ARG) >> 32, 64'(n));
            if (n % 2 == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        e = one32;
        for (int k = 0; k <= TANH_N; k++) begin
            num    = (one32 - e) << FRAC;
            den    = one32 + e;
            tab[k] = 16'(long_div(num + (den >> 1), den));
            e      = (e * $unsigned(sum) + 64'h8000_0000) >> 32;
        end
        return tab;
    endfunction

    localparam t_trim_gain TRIM_GAIN = build_trim();
    localparam t_tanh_tab  TANH_TAB  = build_tanh();

endpackage

[hdl/avf_gain.sv]
// ---------------------------------------------------------------------------
// avf_gain
// Configuration registers and the serial divider for the post gain.
// ---------------------------------------------------------------------------
`include "asymmetric_wavefolder_assert.svh"

module avf_gain (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [avf_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [avf_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    output avf_pkg::t_cfg                       o_cfg
);
    import avf_pkg::*;

    logic [12:0]        r_drive;
    logic signed [9:0]  r_bias;
    logic [8:0]         r_asym;
    logic [8:0]         r_wet;
    logic signed [6:0]  r_trim;
    t_gain_state        r_state, n_state;
    logic [4:0]         r_cnt, n_cnt;
    logic [12:0]        r_rem, n_rem;
    logic [25:0]        r_quo, n_quo;
    logic [PG_BITS-1:0] r_pg, n_pg;
    logic               r_pg_ok, n_pg_ok;

    logic               w_restart;
    logic signed [9:0]  w_bias;
    logic signed [6:0]  w_trim;
    logic [13:0]        w_den;
    logic [25:0]        w_num;
    logic [13:0]        w_trial;
    logic [16:0]        w_ag;
    logic [36:0]        w_prod;
    logic [6:0]         w_tidx;

    assign w_bias = $signed(i_cfg_data[9:0]);
    assign w_trim = $signed(i_cfg_data[6:0]);

    // Clamp each register into its range on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive <= 13'd256;
            r_bias  <= '0;
            r_asym  <= '0;
            r_wet   <= 9'd256;
            r_trim  <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DRIVE_GAIN: begin
                    r_drive <= (i_cfg_data < 13'd26) ? 13'd26 :
                               ((i_cfg_data > 13'd5120) ? 13'd5120 : i_cfg_data);
                end
                CFG_BIAS_OFFSET: begin
                    r_bias <= (w_bias < -10'sd256) ? -10'sd256 :
                              ((w_bias > 10'sd256) ? 10'sd256 : w_bias);
                end
                CFG_ASYMMETRY: begin
                    r_asym <= (i_cfg_data[8:0] > 9'd256) ? 9'd256 : i_cfg_data[8:0];
                end
                CFG_WET_MIX: begin
                    r_wet <= (i_cfg_data[8:0] > 9'd256) ? 9'd256 : i_cfg_data[8:0];
                end
                CFG_TRIM_HALF_DB: begin
                    r_trim <= (w_trim < -7'sd48) ? -7'sd48 :
                              ((w_trim > 7'sd24) ? 7'sd24 : w_trim);
                end
                default: begin
                end
            endcase
        end
    end

    assign w_restart = i_cfg_valid &&
                       ((i_cfg_index == CFG_DRIVE_GAIN) || (i_cfg_index == CFG_TRIM_HALF_DB));

    assign w_den   = 14'(r_drive) + 14'd256;
    assign w_num   = 26'h200_0000 + 26'(w_den >> 1);
    assign w_trial = {r_rem, w_num[r_cnt]};
    assign w_ag    = (r_quo < 26'(AG_FLOOR)) ? AG_FLOOR : r_quo[16:0];
    assign w_tidx  = 7'(r_trim + 7'sd48);
    assign w_prod  = 37'(w_ag) * 37'(TRIM_GAIN[w_tidx]) + 37'd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= GS_IDLE;
            r_cnt   <= '0;
            r_rem   <= '0;
            r_quo   <= '0;
            r_pg    <= PG_BITS'(65536);
            r_pg_ok <= 1'b1;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rem   <= n_rem;
            r_quo   <= n_quo;
            r_pg    <= n_pg;
            r_pg_ok <= n_pg_ok;
        end
    end

    // Restoring divide of 2^25 + d/2 by d, one quotient bit per cycle, then the trim gain scale
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_pg    = r_pg;
        n_pg_ok = r_pg_ok;
        case (r_state)
            GS_IDLE: begin
            end
            GS_DIVIDE: begin
                if (w_trial >= w_den) begin
                    n_rem = 13'(w_trial - w_den);
                    n_quo = {r_quo[24:0], 1'b1};
                end else begin
                    n_rem = w_trial[12:0];
                    n_quo = {r_quo[24:0], 1'b0};
                end
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_state = GS_SCALE;
                end
            end
            GS_SCALE: begin
                n_pg    = w_prod[36:16];
                n_pg_ok = 1'b1;
                n_state = GS_IDLE;
            end
            default: begin
                n_state = GS_IDLE;
            end
        endcase
        if (w_restart) begin
            n_state = GS_DIVIDE;
            n_cnt   = 5'd25;
            n_rem   = '0;
            n_quo   = '0;
            n_pg_ok = 1'b0;
        end
    end

    assign o_cfg = '{
        drive_gain:  r_drive,
        bias_offset: r_bias,
        asymmetry:   r_asym,
        wet_mix:     r_wet,
        pg:          r_pg,
        pg_ok:       r_pg_ok
    };

    `AVF_ASSERT_ALWAYS(a_reset_gain_ready, i_clk, (!i_rst_n) |=> r_pg_ok)
    `AVF_ASSERT(a_busy_not_ready, i_clk, i_rst_n, (r_state != GS_IDLE) |-> !r_pg_ok)
    `AVF_ASSERT(a_drive_restart, i_clk, i_rst_n, (i_cfg_valid && i_cfg_index == CFG_DRIVE_GAIN) |=> (r_state == GS_DIVIDE))

endmodule

[hdl/avf_fold.sv]
// ---------------------------------------------------------------------------
// avf_fold
// Bias, sign-dependent drive, divide by 327680 and triangle fold.
// ---------------------------------------------------------------------------
module avf_fold (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  avf_pkg::t_in_item    i_item,
    input  avf_pkg::t_cfg        i_cfg,
    output logic                 o_valid,
    input  logic                 i_ready,
    output avf_pkg::t_fold_item  o_item
);
    import avf_pkg::*;

    logic [3:0] r_v;
    logic [3:0] w_adv;

    logic signed [31:0] r1_p;
    logic [11:0]        r1_k;
    logic signed [15:0] r1_x;
    logic               r1_last;
    logic signed [44:0] r2_p;
    logic signed [15:0] r2_x;
    logic               r2_last;
    logic [16:0]        r3_quo;
    logic signed [15:0] r3_x;
    logic               r3_last;
    logic signed [16:0] r4_y;
    logic signed [15:0] r4_x;
    logic               r4_last;

    logic signed [17:0] w_s;
    logic [8:0]         w_asel;
    logic [11:0]        w_k;
    logic signed [28:0] w_q1;
    logic [27:0]        w_u;
    logic [57:0]        w_prod;
    logic [16:0]        w_t;
    logic signed [17:0] w_y;

    // Advance a stage when it is empty or the next one advances
    assign w_adv[3] = !r_v[3] || i_ready;
    assign w_adv[2] = !r_v[2] || w_adv[3];
    assign w_adv[1] = !r_v[1] || w_adv[2];
    assign w_adv[0] = !r_v[0] || w_adv[1];
    assign o_ready  = w_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[0]) r_v[0] <= i_valid;
            if (w_adv[1]) r_v[1] <= r_v[0];
            if (w_adv[2]) r_v[2] <= r_v[1];
            if (w_adv[3]) r_v[3] <= r_v[2];
        end
    end

    assign w_s    = 18'(i_item.sample_in) + (18'(i_cfg.bias_offset) <<< 7);
    assign w_asel = !i_item.sample_in[15] ? i_cfg.asymmetry : 9'd256 - i_cfg.asymmetry;
    assign w_k    = 12'd1280 + (12'(w_asel) << 2);

    assign w_q1   = r2_p[44:16];
    assign w_u    = 28'(w_q1 + DIV5_OFFSET);
    assign w_prod = 58'(w_u) * 58'(DIV5_RECIP);

    // Period-4 reflection: only the quotient mod 2^17 matters
    assign w_t = r3_quo + 17'h8000;
    assign w_y = !w_t[16] ? ($signed({1'b0, w_t}) - 18'sd32768)
                          : (18'sd98304 - $signed({1'b0, w_t}));

    always_ff @(posedge i_clk) begin
        if (w_adv[0] && i_valid) begin
            r1_p    <= w_s * $signed({1'b0, i_cfg.drive_gain});
            r1_k    <= w_k;
            r1_x    <= i_item.sample_in;
            r1_last <= i_item.last_in_block;
        end
        if (w_adv[1] && r_v[0]) begin
            r2_p    <= r1_p * $signed({1'b0, r1_k});
            r2_x    <= r1_x;
            r2_last <= r1_last;
        end
        if (w_adv[2] && r_v[1]) begin
            r3_quo  <= w_prod[48:32];
            r3_x    <= r2_x;
            r3_last <= r2_last;
        end
        if (w_adv[3] && r_v[2]) begin
            r4_y    <= 17'(w_y);
            r4_x    <= r3_x;
            r4_last <= r3_last;
        end
    end

    assign o_valid = r_v[3];
    assign o_item  = '{x: r4_x, y: r4_y, last: r4_last};

endmodule

[hdl/avf_clip.sv]
// ---------------------------------------------------------------------------
// avf_clip
// Post gain, dry/wet mix, 0.95 scale and interpolated tanh soft clip.
// ---------------------------------------------------------------------------
module avf_clip (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  avf_pkg::t_fold_item  i_item,
    input  avf_pkg::t_cfg        i_cfg,
    output logic                 o_valid,
    input  logic                 i_ready,
    output avf_pkg::t_out_item   o_item
);
    import avf_pkg::*;

    logic [5:0] r_v;
    logic [5:0] w_adv;

    logic signed [38:0] r1_wp;
    logic signed [15:0] r1_x;
    logic               r1_last;
    logic signed [25:0] r2_ma;
    logic signed [32:0] r2_mb;
    logic               r2_last;
    logic signed [25:0] r3_mix;
    logic               r3_last;
    logic signed [43:0] r4_zp;
    logic               r4_last;
    logic [15:0]        r5_lo;
    logic [15:0]        r5_hi;
    logic [9:0]         r5_fr;
    logic               r5_neg;
    logic               r5_sat;
    logic               r5_last;
    t_out_item          r6_out;

    logic signed [22:0] w_wet;
    logic [8:0]         w_dry;
    logic signed [33:0] w_sum;
    logic signed [27:0] w_z;
    logic [27:0]        w_mag;
    logic [8:0]         w_i0;
    logic [8:0]         w_i1;
    logic [15:0]        w_diff;
    logic [25:0]        w_dp;
    logic [16:0]        w_v;
    logic [15:0]        w_vc;

    assign w_adv[5] = !r_v[5] || i_ready;
    assign w_adv[4] = !r_v[4] || w_adv[5];
    assign w_adv[3] = !r_v[3] || w_adv[4];
    assign w_adv[2] = !r_v[2] || w_adv[3];
    assign w_adv[1] = !r_v[1] || w_adv[2];
    assign w_adv[0] = !r_v[0] || w_adv[1];
    assign o_ready  = w_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[0]) r_v[0] <= i_valid;
            for (int k = 1; k < 6; k++) begin
                if (w_adv[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    assign w_wet = r1_wp[38:16];
    assign w_dry = 9'd256 - i_cfg.wet_mix;
    assign w_sum = 34'(r2_ma) + 34'(r2_mb);

    // Split |z| into table index and 10-bit interpolation fraction
    assign w_z    = r4_zp[43:16];
    assign w_mag  = w_z[27] ? 28'(-w_z) : 28'(w_z);
    assign w_i0   = {1'b0, w_mag[17:10]};
    assign w_i1   = w_i0 + 9'd1;

    assign w_diff = r5_hi - r5_lo;
    assign w_dp   = 26'(w_diff) * 26'(r5_fr);
    assign w_v    = 17'(r5_lo) + 17'(w_dp[25:10]);
    assign w_vc   = (r5_sat || w_v > 17'd32767) ? 16'h7fff : w_v[15:0];

    always_ff @(posedge i_clk) begin
        if (w_adv[0] && i_valid) begin
            r1_wp   <= i_item.y * $signed({1'b0, i_cfg.pg});
            r1_x    <= i_item.x;
            r1_last <= i_item.last;
        end
        if (w_adv[1] && r_v[0]) begin
            r2_ma   <= r1_x * $signed({1'b0, w_dry});
            r2_mb   <= w_wet * $signed({1'b0, i_cfg.wet_mix});
            r2_last <= r1_last;
        end
        if (w_adv[2] && r_v[1]) begin
            r3_mix  <= w_sum[33:8];
            r3_last <= r2_last;
        end
        if (w_adv[3] && r_v[2]) begin
            r4_zp   <= r3_mix * $signed({1'b0, MIX_SCALE});
            r4_last <= r3_last;
        end
        if (w_adv[4] && r_v[3]) begin
            r5_lo   <= TANH_TAB[w_i0];
            r5_hi   <= TANH_TAB[w_i1];
            r5_fr   <= w_mag[9:0];
            r5_neg  <= w_z[27];
            r5_sat  <= |w_mag[27:18];
            r5_last <= r4_last;
        end
        if (w_adv[5] && r_v[4]) begin
            r6_out.sample_out <= r5_neg ? -$signed(w_vc) : $signed(w_vc);
            r6_out.last_out   <= r5_last;
        end
    end

    assign o_valid = r_v[5];
    assign o_item  = r6_out;

endmodule

[hdl/asymmetric_wavefolder.sv]
// ---------------------------------------------------------------------------
// asymmetric_wavefolder
// Biased, asymmetric triangle wavefolder with auto and trim gain, dry/wet
// mix and tanh soft clip on a Q1.15 sample stream.
// ---------------------------------------------------------------------------
// Pipeline: 10 register stages (4 fold + 6 clip).
// Throughput: one item per cycle while the post gain is ready; every stage holds
// under output stall. A write to drive_gain or trim_half_db reruns the 26-bit
// serial divider for the auto gain: input ready drops while the post gain is rebuilt.
// Reset (synchronous, active low) empties the pipeline and loads default gains.
module asymmetric_wavefolder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample input
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  avf_pkg::t_in_item                   i_in,
    // sample output
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output avf_pkg::t_out_item                  o_out,
    // register writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [avf_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [avf_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import avf_pkg::*;

    t_cfg       w_cfg;
    t_fold_item w_fold;
    logic       w_fold_valid;
    logic       w_fold_ready;
    logic       w_clip_ready;

    // Register writes are always accepted
    assign o_cfg_ready = 1'b1;

    avf_gain u_gain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Hold off new items until the post gain matches the registers
    assign o_in_ready = w_fold_ready && w_cfg.pg_ok;

    avf_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid && w_cfg.pg_ok),
        .o_ready (w_fold_ready),
        .i_item  (i_in),
        .i_cfg   (w_cfg),
        .o_valid (w_fold_valid),
        .i_ready (w_clip_ready),
        .o_item  (w_fold)
    );

    avf_clip u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fold_valid),
        .o_ready (w_clip_ready),
        .i_item  (w_fold),
        .i_cfg   (w_cfg),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out)
    );

endmodule

[test/asymmetric_wavefolder_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// asymmetric_wavefolder_tb
// Self-checking bench: streams Q1.15 samples through the wavefolder under a
// series of register settings, predicts each untyped output sample in integer
// arithmetic and compares it field by field, with random gaps and stalls.
// ---------------------------------------------------------------------------
module asymmetric_wavefolder_tb;
    import avf_pkg::*;

    localparam longint ONE_Q    = 64'sd32768;
    localparam int     DRAIN_CYC = 14;   // pipeline depth plus margin
    localparam int     UNMAPPED_LO = 5;  // first register index with no register
    localparam int     UNMAPPED_HI = 7;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       o_in_ready;
    t_in_item   in_item = '0;
    logic       o_out_valid;
    logic       out_ready = 1'b0;
    t_out_item  o_out;
    logic       cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    asymmetric_wavefolder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state: register copies and tables
    longint drive_q8 = 256, bias_q8 = 0, asym_q8 = 0, wet_q8 = 256, trim_hdb = 0;
    longint tanh_lut [TANH_N+1];
    longint trim_base [40] = '{
        65536, 69419, 73533, 77890, 82505, 87394, 92572, 98057,
        103868, 110022, 116541, 123447, 130762, 138510, 146717, 155410,
        164619, 174373, 184706, 195650, 207243, 219523, 232531, 246309,
        260904, 276363, 292739, 310084, 328458, 347920, 368536, 390373,
        413504, 438006, 463959, 491451, 520571, 551417, 584090, 618700
    };

    t_out_item  pending_out [$];
    int         err_count = 0;
    int         out_count = 0;
    bit         no_idle = 1'b0;     // phase without gaps on either side
    bit         hold_done = 1'b0;

    function automatic longint floor_div(longint a, longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0) q = q - 1;
        return q;
    endfunction

    function automatic longint clip_range(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // tanh(8k/N) in Q1.15 from exp(-16/N) series and repeated rounded products
    function automatic void fill_tanh_lut();
        longint unsigned one32, arg, term, step, e, num, den;
        longint sum;
        one32 = 64'd1 << 32;
        arg   = (64'd16 << 32) / TANH_N;
        term  = one32;
        sum   = one32;
        for (int n = 1; n <= 17; n++) begin
            term = ((term * arg) >> 32) / longint'(n);
            if (n % 2 == 1) sum = sum - longint'(term);
            else            sum = sum + longint'(term);
        end
        step = sum;
        e = one32;
        for (int k = 0; k <= TANH_N; k++) begin
            num = (one32 - e) << FRAC;
            den = one32 + e;
            tanh_lut[k] = longint'((num + den / 2) / den);
            e = (e * step + (64'd1 << 31)) >> 32;
        end
    endfunction

    // Clamp a register write into range, drop unknown indexes
    function automatic void apply_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                      logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            CFG_DRIVE_GAIN:   drive_q8 = clip_range(longint'(data), 26, 5120);
            CFG_BIAS_OFFSET:  bias_q8  = clip_range(longint'($signed(data[9:0])), -256, 256);
            CFG_ASYMMETRY:    asym_q8  = clip_range(longint'(data[8:0]), 0, 256);
            CFG_WET_MIX:      wet_q8   = clip_range(longint'(data[8:0]), 0, 256);
            CFG_TRIM_HALF_DB: trim_hdb = clip_range(longint'($signed(data[6:0])), -48, 24);
            default: ;
        endcase
    endfunction

    function automatic t_out_item fold_sample(t_in_item it);
        t_out_item r;
        longint x, s, asel, t, y, ag, tg, pg, wet, mix, z, mag, pos, idx, fr, v;
        x = longint'(it.sample_in);
        s = x + bias_q8 * 128;
        asel = (x >= 0) ? asym_q8 : 256 - asym_q8;
        t = floor_div(s * drive_q8 * (1280 + 4 * asel), 327680);
        // triangle fold, period 4.0
        t = (t + ONE_Q) % (4 * ONE_Q);
        if (t < 0) t = t + 4 * ONE_Q;
        y = (t < 2 * ONE_Q) ? t - ONE_Q : 3 * ONE_Q - t;
        ag = (33554432 + (256 + drive_q8) / 2) / (256 + drive_q8);
        if (ag < 6554) ag = 6554;
        if (trim_hdb >= 0)        tg = trim_base[trim_hdb];
        else if (trim_hdb >= -40) tg = (trim_base[trim_hdb + 40] + 5) / 10;
        else                      tg = (trim_base[trim_hdb + 80] + 50) / 100;
        pg  = (ag * tg + 32768) >>> 16;
        wet = floor_div(y * pg, 65536);
        mix = floor_div(x * (256 - wet_q8) + wet * wet_q8, 256);
        z   = floor_div(mix * 62259, 65536);
        // soft clip by interpolated tanh lookup, saturate the magnitude
        mag = z < 0 ? -z : z;
        pos = mag * TANH_N;
        idx = pos / (8 * ONE_Q);
        fr  = pos % (8 * ONE_Q);
        if (idx >= TANH_N) begin
            v = ONE_Q - 1;
        end else begin
            v = tanh_lut[idx] + ((tanh_lut[idx+1] - tanh_lut[idx]) * fr) / (8 * ONE_Q);
            if (v > ONE_Q - 1) v = ONE_Q - 1;
        end
        r.sample_out = SAMPLE_BITS'(z < 0 ? -v : v);
        r.last_out   = it.last_in_block;
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d, want %0d (output item %0d)", what, got, want,
                 out_count);
        err_count++;
    endtask

    // Check each output item against the oldest queued expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_out.size() == 0) begin
                report("unexpected item", o_out.sample_out, 0);
            end else begin
                want = pending_out.pop_front();
                if (o_out.sample_out !== want.sample_out)
                    report("sample_out", o_out.sample_out, want.sample_out);
                if (o_out.last_out !== want.last_out)
                    report("last_out", o_out.last_out, want.last_out);
            end
            out_count++;
        end
    end

    // Receiver: random hold-off per item, one long stall to back the pipe up
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 19);
            if (!hold_done && out_count >= 700) begin
                gap = 300;
                hold_done = 1'b1;
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // Offer one item, hold it until accepted; expectation is queued at accept
    task automatic send_sample(t_in_item it, bit typed, t_out_item typed_out);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        if (typed) pending_out.push_back(typed_out);
        else       pending_out.push_back(fold_sample(it));
        @(negedge i_clk);
    endtask

    // Pause the sender until every output is back and the pipe is empty
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_out.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx,
                             logic [CFG_DATA_BITS-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, data);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] smp;
        logic                          last;
        bit                            typed;
        logic signed [SAMPLE_BITS-1:0] want;
    } t_probe_row;

    // Directed rows; only the silent sample under reset settings is typed in
    t_probe_row probe_rows [14] = '{
        '{16'sd0,      1'b0, 1'b1, 16'sd0},
        '{16'sd32767,  1'b1, 1'b0, 16'sd0},
        '{-16'sd32768, 1'b0, 1'b0, 16'sd0},
        '{16'sd1,      1'b0, 1'b0, 16'sd0},
        '{-16'sd1,     1'b1, 1'b0, 16'sd0},
        '{16'sd16384,  1'b0, 1'b0, 16'sd0},
        '{-16'sd16384, 1'b0, 1'b0, 16'sd0},
        '{16'sd8192,   1'b0, 1'b0, 16'sd0},
        '{-16'sd8192,  1'b1, 1'b0, 16'sd0},
        '{16'sd21845,  1'b0, 1'b0, 16'sd0},
        '{-16'sd21846, 1'b0, 1'b0, 16'sd0},
        '{16'sh5555,   1'b1, 1'b0, 16'sd0},
        '{16'shAAAA,   1'b0, 1'b0, 16'sd0},
        '{16'sd100,    1'b1, 1'b0, 16'sd0}
    };

    // Register settings per phase: drive, bias, asymmetry, wet, trim (raw data)
    typedef logic [CFG_DATA_BITS-1:0] t_reg_set [5];
    t_reg_set fixed_sets [5] = '{
        '{13'd26,   13'h200 | 13'h100, 13'd0,   13'd0,   13'h50},   // all low ends
        '{13'd5120, 13'd256,           13'd256, 13'd256, 13'd24},   // all high ends
        '{13'd0,    13'h200,           13'h1FF, 13'h1FF, 13'h40},   // clamped below/above
        '{13'h1FFF, 13'h1FF,           13'd128, 13'd128, 13'h3F},   // clamped above
        '{13'd700,  13'h3C0,           13'd64,  13'd200, 13'h58}    // trim -40
    };

    task automatic run_probe();
        t_in_item  it;
        t_out_item o;
        foreach (probe_rows[i]) begin
            it.sample_in     = probe_rows[i].smp;
            it.last_in_block = probe_rows[i].last;
            o.sample_out     = probe_rows[i].want;
            o.last_out       = probe_rows[i].last;
            send_sample(it, probe_rows[i].typed && drive_q8 == 256 && bias_q8 == 0, o);
        end
    endtask

    task automatic run_random(int count);
        t_in_item  it;
        t_out_item unused;
        unused = '0;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 3))
                0:       it.sample_in = SAMPLE_BITS'($urandom_range(0, 600) - 300);
                1:       it.sample_in = $urandom_range(0, 1) ?
                                        SAMPLE_BITS'(16'h7FFF - $urandom_range(0, 40)) :
                                        SAMPLE_BITS'(16'h8000 + $urandom_range(0, 40));
                default: it.sample_in = SAMPLE_BITS'($urandom);
            endcase
            it.last_in_block = ($urandom_range(0, 7) == 0);
            send_sample(it, 1'b0, unused);
        end
    endtask

    task automatic load_set(t_reg_set rs);
        write_reg(CFG_DRIVE_GAIN,   rs[0]);
        write_reg(CFG_BIAS_OFFSET,  rs[1]);
        write_reg(CFG_ASYMMETRY,    rs[2]);
        write_reg(CFG_WET_MIX,      rs[3]);
        write_reg(CFG_TRIM_HALF_DB, rs[4]);
        // a write to no register at all must change nothing
        write_reg(CFG_INDEX_BITS'($urandom_range(UNMAPPED_LO, UNMAPPED_HI)),
                  CFG_DATA_BITS'($urandom));
    endtask

    initial begin
        t_reg_set rs;
        fill_tanh_lut();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings
        run_probe();
        run_random(150);
        drain();

        // fixed edge settings, directed rows then random under each
        foreach (fixed_sets[p]) begin
            no_idle = (p == 1);
            load_set(fixed_sets[p]);
            run_probe();
            run_random(110);
            drain();
        end

        // random settings
        for (int p = 0; p < 9; p++) begin
            no_idle = ($urandom_range(0, 3) == 0);
            for (int r = 0; r < 5; r++) rs[r] = CFG_DATA_BITS'($urandom);
            if (p % 2 == 0) begin
                // keep most phases inside the legal ranges
                rs[0] = CFG_DATA_BITS'($urandom_range(26, 5120));
                rs[1] = 13'($urandom_range(0, 512) - 256);
                rs[2] = CFG_DATA_BITS'($urandom_range(0, 256));
                rs[3] = CFG_DATA_BITS'($urandom_range(0, 256));
                rs[4] = 13'($urandom_range(0, 72) - 48);
            end
            load_set(rs);
            run_random(110);
            drain();
        end

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #1500000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/avf_pkg.sv
hdl/avf_gain.sv
hdl/avf_fold.sv
hdl/avf_clip.sv
hdl/asymmetric_wavefolder.sv
test/asymmetric_wavefolder_tb.sv
